FILE: rtl/sks_pkg.sv
package sks_pkg;

   // Scan modes.
   localparam logic [3:0] M_IDLE        = 4'd0;
   localparam logic [3:0] M_COMMENT     = 4'd1;
   localparam logic [3:0] M_NUM_INT     = 4'd2;
   localparam logic [3:0] M_NUM_FRAC    = 4'd3;
   localparam logic [3:0] M_STRING      = 4'd4;
   localparam logic [3:0] M_IDENT       = 4'd5;
   localparam logic [3:0] M_IDENT_PLAIN = 4'd6;
   localparam logic [3:0] M_EQ          = 4'd7;
   localparam logic [3:0] M_LT          = 4'd8;
   localparam logic [3:0] M_GT          = 4'd9;
   localparam logic [3:0] M_BANG        = 4'd10;
   localparam logic [3:0] M_AMP         = 4'd11;
   localparam logic [3:0] M_BAR         = 4'd12;

   // Token kinds.
   localparam logic [5:0] K_PAYLOAD  = 6'd0;
   localparam logic [5:0] K_IDENT    = 6'd1;
   localparam logic [5:0] K_NUMBER   = 6'd2;
   localparam logic [5:0] K_STRING   = 6'd3;
   localparam logic [5:0] K_PLUS     = 6'd4;
   localparam logic [5:0] K_MINUS    = 6'd5;
   localparam logic [5:0] K_DIV      = 6'd6;
   localparam logic [5:0] K_MUL      = 6'd7;
   localparam logic [5:0] K_ATR      = 6'd8;
   localparam logic [5:0] K_EQUAL    = 6'd9;
   localparam logic [5:0] K_LESS     = 6'd10;
   localparam logic [5:0] K_LESSEQ   = 6'd11;
   localparam logic [5:0] K_GREATER  = 6'd12;
   localparam logic [5:0] K_GREATEQ  = 6'd13;
   localparam logic [5:0] K_NOT      = 6'd14;
   localparam logic [5:0] K_INEQUAL  = 6'd15;
   localparam logic [5:0] K_AND      = 6'd16;
   localparam logic [5:0] K_OR       = 6'd17;
   localparam logic [5:0] K_KEYWORD0 = 6'd18;
   localparam logic [5:0] K_LITERAL  = 6'd33;
   localparam logic [5:0] K_END      = 6'd34;

   // Keyword table: all keywords back to back, and the start of each one.
   localparam int NUM_KW = 15;
   localparam logic [64*8-1:0] KW_TEXT =
      "ifprintelsevarbreaknullwhileclasssuperreturntruethisfalsefuncfor";
   localparam logic [6:0] KW_START [0:15] = '{
      7'd0, 7'd2, 7'd7, 7'd11, 7'd14, 7'd19, 7'd23, 7'd28,
      7'd33, 7'd38, 7'd44, 7'd48, 7'd52, 7'd57, 7'd61, 7'd64};

   typedef struct packed {
      logic [5:0] kind;
      logic [7:0] char_value;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [3:0]   mode;
      logic [5:0]   node;
      logic [1:0]   count;
      rsp_item_type res0;
      rsp_item_type res1;
   } scan_type;

endpackage

FILE: rtl/sks_step.sv
module sks_step (
   input  logic [3:0]        scan_mode,
   input  logic [5:0]        trie_node,
   input  logic [7:0]        ch,
   input  logic              end_of_input,
   output sks_pkg::scan_type next_scan
);

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_TILDE = 8'h7E;

   function automatic logic is_space(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic [7:0] kw_char(logic [5:0] idx);
      return sks_pkg::KW_TEXT[(63 - idx) * 8 +: 8];
   endfunction

   function automatic logic [2:0] kw_len(logic [3:0] k);
      logic [6:0] len;
      len = sks_pkg::KW_START[k + 4'd1] - sks_pkg::KW_START[k];
      return len[2:0];
   endfunction

   // Keyword that owns a table position.
   function automatic logic [3:0] kw_of(logic [5:0] node);
      logic [3:0] k;
      k = '0;
      for (int i = 1; i < sks_pkg::NUM_KW; i++) begin
         if ({1'b0, node} >= sks_pkg::KW_START[i]) k = 4'(i);
      end
      return k;
   endfunction

   // Number of keyword characters matched so far.
   function automatic logic [2:0] prefix_len(logic [5:0] node, logic [3:0] k);
      logic [6:0] diff;
      diff = {1'b0, node} - sks_pkg::KW_START[k] + 7'd1;
      return diff[2:0];
   endfunction

   // Returns {hit, node} for the first keyword that starts with c.
   function automatic logic [6:0] trie_begin(logic [7:0] c);
      logic       hit;
      logic [5:0] node;
      hit  = 1'b0;
      node = '0;
      for (int k = 0; k < sks_pkg::NUM_KW; k++) begin
         if (!hit && kw_char(sks_pkg::KW_START[k][5:0]) == c) begin
            hit  = 1'b1;
            node = sks_pkg::KW_START[k][5:0];
         end
      end
      return {hit, node};
   endfunction

   // Returns {hit, node} for the first keyword that shares the matched prefix
   // and continues with c.
   function automatic logic [6:0] trie_advance(logic [5:0] node, logic [7:0] c);
      logic [3:0] k;
      logic [2:0] p;
      logic [6:0] base_k;
      logic [6:0] base_j;
      logic [6:0] pos;
      logic       match;
      logic       hit;
      logic [5:0] next;
      k      = kw_of(node);
      p      = prefix_len(node, k);
      base_k = sks_pkg::KW_START[k];
      hit    = 1'b0;
      next   = node;
      for (int j = 0; j < sks_pkg::NUM_KW; j++) begin
         base_j = sks_pkg::KW_START[j];
         match  = !hit && (kw_len(4'(j)) > p);
         for (int q = 0; q < 6; q++) begin
            if (3'(q) < p &&
                kw_char(6'(base_j + 7'(q))) != kw_char(6'(base_k + 7'(q)))) begin
               match = 1'b0;
            end
         end
         pos = base_j + {4'b0, p};
         if (match && kw_char(pos[5:0]) == c) begin
            hit  = 1'b1;
            next = pos[5:0];
         end
      end
      return {hit, next};
   endfunction

   // A keyword counts only when the whole identifier matched it.
   function automatic logic [5:0] ident_kind(logic [3:0] mode, logic [5:0] node);
      logic [3:0] k;
      logic [5:0] kind;
      k    = kw_of(node);
      kind = sks_pkg::K_IDENT;
      if (mode == sks_pkg::M_IDENT && prefix_len(node, k) == kw_len(k)) begin
         kind = sks_pkg::K_KEYWORD0 + {2'b0, k};
      end
      return kind;
   endfunction

   function automatic sks_pkg::scan_type put_res(sks_pkg::scan_type s,
                                                 logic [5:0] kind, logic [7:0] chv);
      sks_pkg::scan_type r;
      r = s;
      if (s.count == 2'd0) begin
         r.res0  = '{kind: kind, char_value: chv, last: 1'b0};
         r.count = 2'd1;
      end else if (s.count == 2'd1) begin
         r.res1  = '{kind: kind, char_value: chv, last: 1'b0};
         r.count = 2'd2;
      end
      return r;
   endfunction

   function automatic sks_pkg::scan_type start_char(sks_pkg::scan_type s, logic [7:0] c);
      sks_pkg::scan_type r;
      logic [6:0]        tb;
      r      = s;
      r.mode = sks_pkg::M_IDLE;
      r.node = '0;
      tb     = trie_begin(c);
      if (is_space(c)) begin
         r = r;
      end else if (c == CH_HASH) begin
         r.mode = sks_pkg::M_COMMENT;
      end else if (is_digit(c)) begin
         r      = put_res(r, sks_pkg::K_PAYLOAD, c);
         r.mode = sks_pkg::M_NUM_INT;
      end else if (c == CH_QUOTE) begin
         r.mode = sks_pkg::M_STRING;
      end else if (is_alpha(c)) begin
         r = put_res(r, sks_pkg::K_PAYLOAD, c);
         if (tb[6]) begin
            r.mode = sks_pkg::M_IDENT;
            r.node = tb[5:0];
         end else begin
            r.mode = sks_pkg::M_IDENT_PLAIN;
         end
      end else begin
         case (c)
            CH_PLUS:  r = put_res(r, sks_pkg::K_PLUS, 8'd0);
            CH_MINUS: r = put_res(r, sks_pkg::K_MINUS, 8'd0);
            CH_DIV:   r = put_res(r, sks_pkg::K_DIV, 8'd0);
            CH_MUL:   r = put_res(r, sks_pkg::K_MUL, 8'd0);
            CH_EQ:    r.mode = sks_pkg::M_EQ;
            CH_LT:    r.mode = sks_pkg::M_LT;
            CH_GT:    r.mode = sks_pkg::M_GT;
            CH_BANG:  r.mode = sks_pkg::M_BANG;
            CH_AMP:   r.mode = sks_pkg::M_AMP;
            CH_BAR:   r.mode = sks_pkg::M_BAR;
            default:  r = put_res(r, sks_pkg::K_LITERAL, c);
         endcase
      end
      return r;
   endfunction

   // A pending operator either pairs with '=' or goes out alone.
   function automatic sks_pkg::scan_type pair_op(sks_pkg::scan_type s, logic [7:0] c,
                                                 logic [5:0] kd, logic [5:0] ks);
      sks_pkg::scan_type r;
      if (c == CH_EQ) begin
         r      = put_res(s, kd, 8'd0);
         r.mode = sks_pkg::M_IDLE;
      end else begin
         r = start_char(put_res(s, ks, 8'd0), c);
      end
      return r;
   endfunction

   sks_pkg::scan_type s;
   logic [6:0]        adv;

   always_comb begin
      s.mode  = scan_mode;
      s.node  = trie_node;
      s.count = 2'd0;
      s.res0  = '0;
      s.res1  = '0;
      adv     = trie_advance(trie_node, ch);
      if (end_of_input) begin
         unique case (scan_mode) inside
            sks_pkg::M_NUM_INT, sks_pkg::M_NUM_FRAC:
               s = put_res(s, sks_pkg::K_NUMBER, 8'd0);
            sks_pkg::M_IDENT, sks_pkg::M_IDENT_PLAIN:
               s = put_res(s, ident_kind(scan_mode, trie_node), 8'd0);
            sks_pkg::M_EQ:   s = put_res(s, sks_pkg::K_ATR, 8'd0);
            sks_pkg::M_LT:   s = put_res(s, sks_pkg::K_LESS, 8'd0);
            sks_pkg::M_GT:   s = put_res(s, sks_pkg::K_GREATER, 8'd0);
            sks_pkg::M_BANG: s = put_res(s, sks_pkg::K_NOT, 8'd0);
            sks_pkg::M_AMP:  s = put_res(s, sks_pkg::K_LITERAL, CH_AMP);
            sks_pkg::M_BAR:  s = put_res(s, sks_pkg::K_LITERAL, CH_BAR);
            default:         s = s;
         endcase
         s      = put_res(s, sks_pkg::K_END, 8'd0);
         s.mode = sks_pkg::M_IDLE;
         s.node = '0;
      end else begin
         unique case (scan_mode) inside
            sks_pkg::M_COMMENT: begin
               if (ch == CH_CR || ch == CH_LF) s.mode = sks_pkg::M_IDLE;
            end
            sks_pkg::M_NUM_INT: begin
               if (is_digit(ch)) begin
                  s = put_res(s, sks_pkg::K_PAYLOAD, ch);
               end else if (ch == CH_DOT) begin
                  s      = put_res(s, sks_pkg::K_PAYLOAD, ch);
                  s.mode = sks_pkg::M_NUM_FRAC;
               end else begin
                  s = start_char(put_res(s, sks_pkg::K_NUMBER, 8'd0), ch);
               end
            end
            sks_pkg::M_NUM_FRAC: begin
               if (is_digit(ch)) begin
                  s = put_res(s, sks_pkg::K_PAYLOAD, ch);
               end else begin
                  s = start_char(put_res(s, sks_pkg::K_NUMBER, 8'd0), ch);
               end
            end
            sks_pkg::M_STRING: begin
               if (ch == CH_QUOTE) begin
                  s      = put_res(s, sks_pkg::K_STRING, 8'd0);
                  s.mode = sks_pkg::M_IDLE;
               end else if (ch >= CH_SPACE && ch <= CH_TILDE) begin
                  s = put_res(s, sks_pkg::K_PAYLOAD, ch);
               end else begin
                  s      = put_res(s, sks_pkg::K_LITERAL, ch);
                  s.mode = sks_pkg::M_IDLE;
               end
            end
            sks_pkg::M_IDENT, sks_pkg::M_IDENT_PLAIN: begin
               if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDER) begin
                  s = put_res(s, sks_pkg::K_PAYLOAD, ch);
                  if (scan_mode == sks_pkg::M_IDENT) begin
                     if (adv[6]) begin
                        s.node = adv[5:0];
                     end else begin
                        s.mode = sks_pkg::M_IDENT_PLAIN;
                        s.node = '0;
                     end
                  end
               end else begin
                  s = start_char(put_res(s, ident_kind(scan_mode, trie_node), 8'd0), ch);
               end
            end
            sks_pkg::M_EQ:   s = pair_op(s, ch, sks_pkg::K_EQUAL, sks_pkg::K_ATR);
            sks_pkg::M_LT:   s = pair_op(s, ch, sks_pkg::K_LESSEQ, sks_pkg::K_LESS);
            sks_pkg::M_GT:   s = pair_op(s, ch, sks_pkg::K_GREATEQ, sks_pkg::K_GREATER);
            sks_pkg::M_BANG: s = pair_op(s, ch, sks_pkg::K_INEQUAL, sks_pkg::K_NOT);
            sks_pkg::M_AMP: begin
               if (ch == CH_AMP) s = put_res(s, sks_pkg::K_AND, 8'd0);
               else              s = put_res(s, sks_pkg::K_LITERAL, ch);
               s.mode = sks_pkg::M_IDLE;
            end
            sks_pkg::M_BAR: begin
               if (ch == CH_BAR) s = put_res(s, sks_pkg::K_OR, 8'd0);
               else              s = put_res(s, sks_pkg::K_LITERAL, ch);
               s.mode = sks_pkg::M_IDLE;
            end
            default: s = start_char(s, ch);
         endcase
      end
      if (s.count == 2'd2) begin
         s.res1.last = 1'b1;
      end else if (s.count == 2'd1) begin
         s.res0.last = 1'b1;
      end
      next_scan = s;
   end

endmodule

FILE: rtl/script_lexer_keyword_scanner_top.sv
// Channel   Direction  Ports                                   Carries
// req_      in         req_valid/ready, ch, end_of_input       one source byte
// rsp_      out        rsp_valid/ready, kind, char_value, last  one token result
//
// Each item is scanned in the cycle it is accepted and its zero, one or two
// results land in a two-entry result buffer that drives the rsp_ ports.
// An item with at most one result can be taken every cycle while rsp_ready
// is high; an item with two results holds off the next item while the buffer drains.
// Synchronous reset returns the scanner to idle at the root of the keyword trie.
// A stalled rsp_ready drops req_ready as soon as the buffer holds a result.
module script_lexer_keyword_scanner_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_kind,
   output logic [7:0] rsp_char_value,
   output logic       rsp_last
);

   logic [3:0]            mode_ff, mode_in;
   logic [5:0]            node_ff, node_in;
   logic [1:0]            count_ff, count_in;
   sks_pkg::rsp_item_type q0_ff, q0_in;
   sks_pkg::rsp_item_type q1_ff, q1_in;
   sks_pkg::scan_type     next_scan;
   logic                  accept;
   logic                  pop;

   sks_step u_step (
      .scan_mode    (mode_ff),
      .trie_node    (node_ff),
      .ch           (req_ch),
      .end_of_input (req_end_of_input),
      .next_scan    (next_scan)
   );

   assign rsp_valid      = count_ff != 2'd0;
   assign pop            = rsp_valid && rsp_ready;
   // The buffer must be empty after this cycle's pop to take a new item.
   assign req_ready      = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_ready);
   assign accept         = req_valid && req_ready;
   assign rsp_kind       = q0_ff.kind;
   assign rsp_char_value = q0_ff.char_value;
   assign rsp_last       = q0_ff.last;

   always_comb begin
      mode_in  = mode_ff;
      node_in  = node_ff;
      count_in = count_ff;
      q0_in    = q0_ff;
      q1_in    = q1_ff;
      if (accept) begin
         mode_in  = next_scan.mode;
         node_in  = next_scan.node;
         count_in = next_scan.count;
         q0_in    = next_scan.res0;
         q1_in    = next_scan.res1;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         q0_in    = q1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= sks_pkg::M_IDLE;
         node_ff  <= '0;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         node_ff  <= node_in;
         count_ff <= count_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

endmodule
